>>> rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, codes and sizes of the MSI snooping coherence controller.
// ----------------------------------------------------------------------------
package msc_pkg;

   localparam int LINES      = 1024;
   localparam int IDX_BITS   = $clog2(LINES);
   localparam int ADDR_BITS  = 32;
   localparam int NODE_BITS  = 4;
   localparam int OP_BITS    = 3;
   localparam int INDEX_BITS = 10;

   localparam logic [OP_BITS-1:0] OP_LOAD  = 3'd0;
   localparam logic [OP_BITS-1:0] OP_STORE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_GETS  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_GETM  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_DATA  = 3'd4;

   localparam logic [1:0] BUS_NONE = 2'd0;
   localparam logic [1:0] BUS_GETS = 2'd1;
   localparam logic [1:0] BUS_GETM = 2'd2;

   localparam logic [1:0] ERR_OK      = 2'd0;
   localparam logic [1:0] ERR_PENDING = 2'd1;
   localparam logic [1:0] ERR_ILLEGAL = 2'd2;

   typedef enum logic [1:0] {
      LS_I = 2'd0,
      LS_P = 2'd1,
      LS_S = 2'd2,
      LS_M = 2'd3
   } line_state_type;

   typedef enum logic [1:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_LOOKUP
   } ctrl_state_type;

   typedef struct packed {
      line_state_type state;
      line_state_type target;
   } entry_type;

   typedef struct packed {
      logic [OP_BITS-1:0]    operation;
      logic [INDEX_BITS-1:0] line_index;
      logic [ADDR_BITS-1:0]  block_addr;
      logic [NODE_BITS-1:0]  requester;
   } req_type;

   typedef struct packed {
      logic [1:0]           bus_request;
      logic [ADDR_BITS-1:0] out_addr;
      logic                 data_to_proc;
      logic                 data_on_bus;
      logic [NODE_BITS-1:0] data_dest;
      logic                 shared_line;
      logic                 miss;
      logic [1:0]           error;
   } rsp_type;

endpackage

>>> rtl/msc_if.sv
// ----------------------------------------------------------------------------
// msc_req_if / msc_rsp_if
// Valid/ready channels for requests into and responses out of the controller.
// ----------------------------------------------------------------------------
interface msc_req_if
   import msc_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    operation;
   logic [INDEX_BITS-1:0] line_index;
   logic [ADDR_BITS-1:0]  block_addr;
   logic [NODE_BITS-1:0]  requester;

   modport source (output valid, operation, line_index, block_addr, requester,
                   input ready);
   modport sink   (input valid, operation, line_index, block_addr, requester,
                   output ready);
endinterface

interface msc_rsp_if
   import msc_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           bus_request;
   logic [ADDR_BITS-1:0] out_addr;
   logic                 data_to_proc;
   logic                 data_on_bus;
   logic [NODE_BITS-1:0] data_dest;
   logic                 shared_line;
   logic                 miss;
   logic [1:0]           error;

   modport source (output valid, bus_request, out_addr, data_to_proc, data_on_bus,
                   data_dest, shared_line, miss, error, input ready);
   modport sink   (input valid, bus_request, out_addr, data_to_proc, data_on_bus,
                   data_dest, shared_line, miss, error, output ready);
endinterface

>>> rtl/msc_line_mem.sv
// ----------------------------------------------------------------------------
// msc_line_mem
// Line table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msc_line_mem
   import msc_pkg::*;
(
   input  logic                clock,
   input  logic                rd_en,
   input  logic [IDX_BITS-1:0] rd_idx,
   output entry_type           rd_data,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_idx,
   input  entry_type           wr_data
);

   entry_type mem [LINES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/msc_proto.sv
// ----------------------------------------------------------------------------
// msc_proto
// MSI transition logic: next line entry and response for one transfer.
// ----------------------------------------------------------------------------
module msc_proto
   import msc_pkg::*;
(
   input  req_type   item,
   input  entry_type cur,
   output entry_type nxt,
   output rsp_type   rsp
);

   logic [1:0] bus;
   logic       dproc;
   logic       dbus;
   logic       shared;
   logic       miss;
   logic [1:0] err;

   always_comb begin
      nxt    = cur;
      bus    = BUS_NONE;
      dproc  = 1'b0;
      dbus   = 1'b0;
      shared = 1'b0;
      miss   = 1'b0;
      err    = ERR_OK;
      case (item.operation) inside
         OP_LOAD, OP_STORE: begin
            case (cur.state)
               LS_I: begin
                  bus       = (item.operation == OP_LOAD) ? BUS_GETS : BUS_GETM;
                  nxt.state = LS_P;
                  miss      = 1'b1;
               end
               LS_S: begin
                  if (item.operation == OP_LOAD) begin
                     dproc = 1'b1;
                  end else begin
                     bus       = BUS_GETM;
                     nxt.state = LS_P;
                     miss      = 1'b1;
                  end
               end
               LS_M: dproc = 1'b1;
               default: err = ERR_PENDING;
            endcase
         end
         OP_GETS, OP_GETM, OP_DATA: begin
            case (cur.state)
               LS_P: begin
                  if (item.operation == OP_GETS) begin
                     nxt.target = LS_S;
                  end else if (item.operation == OP_GETM) begin
                     nxt.target = LS_M;
                  end else begin
                     dproc     = 1'b1;
                     nxt.state = cur.target;
                  end
               end
               LS_S: begin
                  if (item.operation == OP_GETM) begin
                     nxt.state = LS_I;
                  end
               end
               LS_M: begin
                  if (item.operation == OP_DATA) begin
                     err = ERR_ILLEGAL;
                  end else begin
                     shared    = 1'b1;
                     dbus      = 1'b1;
                     nxt.state = (item.operation == OP_GETS) ? LS_S : LS_I;
                  end
               end
               default: ;
            endcase
         end
         default: err = ERR_ILLEGAL;
      endcase

      rsp.bus_request  = bus;
      rsp.out_addr     = ((bus != BUS_NONE) || dproc || dbus) ? item.block_addr : '0;
      rsp.data_to_proc = dproc;
      rsp.data_on_bus  = dbus;
      rsp.data_dest    = dbus ? item.requester : '0;
      rsp.shared_line  = shared;
      rsp.miss         = miss;
      rsp.error        = err;
   end

endmodule

>>> rtl/msi_snoop_coherence_controller.sv
// ----------------------------------------------------------------------------
// msi_snoop_coherence_controller
// Per-line MSI coherence state for 1024 lines, held in a single-port-read,
// single-port-write table. After reset the table is swept to invalid, one
// line a cycle, during which no request is taken. Each request is then
// handled in a read step that reads the line entry and an update step that
// updates it and registers the response; as the table's read data is
// registered, a new request is taken only after the previous update. A new
// request is taken while the previous response still waits in the output
// register; a response that is not taken stalls only the following update.
// ----------------------------------------------------------------------------
module msi_snoop_coherence_controller
   import msc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   msc_req_if.sink    req_chan,
   msc_rsp_if.source  rsp_chan
);

   ctrl_state_type      state_ff, state_in;
   logic [IDX_BITS-1:0] clr_ff, clr_in;
   req_type             item_ff, item_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                rd_en;
   logic                wr_en;
   logic [IDX_BITS-1:0] wr_idx;
   entry_type           wr_data;
   entry_type           rd_data;
   entry_type           nxt_entry;
   rsp_type             nxt_rsp;
   logic                accept;
   logic                out_free;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   msc_line_mem u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_idx  (req_chan.line_index[IDX_BITS-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data)
   );

   msc_proto u_proto (
      .item (item_ff),
      .cur  (rd_data),
      .nxt  (nxt_entry),
      .rsp  (nxt_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      item_in        = item_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      req_chan.ready = 1'b0;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_idx         = item_ff.line_index[IDX_BITS-1:0];
      wr_data        = nxt_entry;
      unique case (state_ff)
         CS_CLEAR: begin
            wr_en   = 1'b1;
            wr_idx  = clr_ff;
            wr_data = '{state: LS_I, target: LS_I};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_BITS'(LINES - 1)) begin
               state_in = CS_IDLE;
            end
         end
         CS_IDLE: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               rd_en    = 1'b1;
               item_in  = '{operation:  req_chan.operation,
                            line_index: req_chan.line_index,
                            block_addr: req_chan.block_addr,
                            requester:  req_chan.requester};
               state_in = CS_LOOKUP;
            end
         end
         CS_LOOKUP: begin
            // hold the read entry until the output register frees up
            if (out_free) begin
               wr_en        = 1'b1;
               rsp_in       = nxt_rsp;
               rsp_valid_in = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: state_in = CS_CLEAR;
      endcase
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.bus_request  = rsp_ff.bus_request;
   assign rsp_chan.out_addr     = rsp_ff.out_addr;
   assign rsp_chan.data_to_proc = rsp_ff.data_to_proc;
   assign rsp_chan.data_on_bus  = rsp_ff.data_on_bus;
   assign rsp_chan.data_dest    = rsp_ff.data_dest;
   assign rsp_chan.shared_line  = rsp_ff.shared_line;
   assign rsp_chan.miss         = rsp_ff.miss;
   assign rsp_chan.error        = rsp_ff.error;

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == CS_LOOKUP)
      else $error("transfer taken without table lookup");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error != ERR_OK |->
         rsp_ff.bus_request == BUS_NONE && !rsp_ff.data_to_proc &&
         !rsp_ff.data_on_bus && !rsp_ff.shared_line && !rsp_ff.miss)
      else $error("error response carries other fields");

   a_dest_with_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.data_on_bus |-> rsp_ff.data_dest == '0)
      else $error("data destination without bus data");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_IDLE |-> !wr_en)
      else $error("table written while idle");

   a_rsp_on_update: assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_LOOKUP && wr_en |=> rsp_valid_ff)
      else $error("table updated without response");

endmodule
